[rtl/suks_pkg.sv]
// Shared types and constants for the sorted unique key set unit.
// The controller, the datapath and the top level all use this package.
package suks_pkg;

   // Default number of key slots in the table.
   localparam int TABLE_DEPTH_DEF = 64;

   // Widths of the payload fields.
   localparam int KEY_W    = 32;
   localparam int CMD_W    = 2;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 7;

   // Command codes carried by a request.
   typedef enum logic [CMD_W-1:0] {
      CMD_INSERT = 2'd0,
      CMD_DELETE = 2'd1,
      CMD_SEARCH = 2'd2
   } cmd_type;

   // Status codes returned with each response.
   typedef enum logic [STATUS_W-1:0] {
      ST_CHANGED  = 2'd0,
      ST_NOCHANGE = 2'd1,
      ST_FULL     = 2'd2
   } status_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;   // latch the request fields
      logic compare;   // register per-slot compare flags
      logic execute;   // update the table and load the response register
   } ctrl_cmd_type;

endpackage

[rtl/suks_ctrl.sv]
// Controller state machine of the sorted unique key set unit.
// Sequences capture, compare and execute; owns the handshake flags. Uses suks_pkg.
module suks_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output suks_pkg::ctrl_cmd_type cmd
);

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_CMP  = 3'b010,
      S_EXEC = 3'b100
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;
   logic      req_xfer;

   // The response register can take a new result when empty or being drained.
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign req_xfer = req_valid && req_ready;

   // Next state and command decode.
   always_comb begin
      state_in    = state_ff;
      req_ready   = 1'b0;
      cmd.compare = 1'b0;
      cmd.execute = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               state_in = S_CMP;
            end
         end
         S_CMP: begin
            cmd.compare = 1'b1;
            state_in    = S_EXEC;
         end
         S_EXEC: begin
            // The table update lands at this edge, so a new request may be
            // taken here and compared against the updated table next cycle.
            if (out_free) begin
               cmd.execute = 1'b1;
               req_ready   = 1'b1;
               state_in    = req_valid ? S_CMP : S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      cmd.capture = req_xfer;
   end

   // Response valid flag: set on execute, cleared when the result is taken.
   always_comb begin
      if (cmd.execute) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

[rtl/suks_datapath.sv]
// Datapath of the sorted unique key set unit: a row of key slots with
// per-slot comparators, neighbor shift paths, the count and the response register.
// Uses suks_pkg for widths, codes and the command struct.
module suks_datapath #(
   parameter int TABLE_DEPTH = suks_pkg::TABLE_DEPTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  suks_pkg::ctrl_cmd_type              cmd,
   input  logic [suks_pkg::CMD_W-1:0]          req_cmd,
   input  logic signed [suks_pkg::KEY_W-1:0]   req_key,
   output logic [suks_pkg::STATUS_W-1:0]       rsp_status,
   output logic                                rsp_found,
   output logic [suks_pkg::COUNT_W-1:0]        rsp_count,
   output logic [$clog2(TABLE_DEPTH+1)-1:0]    entry_count
);

   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(TABLE_DEPTH);

   // Captured request.
   logic [suks_pkg::CMD_W-1:0]        cmd_ff;
   logic signed [suks_pkg::KEY_W-1:0] key_ff;

   // Key slots and their compare flags.
   logic signed [suks_pkg::KEY_W-1:0] cell_ff [TABLE_DEPTH];
   logic signed [suks_pkg::KEY_W-1:0] cell_in [TABLE_DEPTH];
   logic [TABLE_DEPTH-1:0]            lt_ff, lt_in;
   logic [TABLE_DEPTH-1:0]            eq_ff, eq_in;

   logic [CNT_W-1:0]                  count_ff, count_in;
   logic [suks_pkg::STATUS_W-1:0]     status_ff, status_in;
   logic                              found_ff;
   logic [suks_pkg::COUNT_W-1:0]      rsp_count_ff;

   logic hit;
   logic full;
   logic do_ins;
   logic do_del;

   // Request capture.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         cmd_ff <= req_cmd;
         key_ff <= req_key;
      end
   end

   // Per-slot compare and next value. Slots below the insert position keep
   // their key; the slot at the position takes the new key and the rest take
   // their lower neighbor. On delete, slots from the hit onward take their
   // upper neighbor.
   for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
      localparam logic [CNT_W-1:0] IDX = CNT_W'(i);
      logic                              occupied;
      logic                              prev_lt;
      logic signed [suks_pkg::KEY_W-1:0] prev_key;
      logic signed [suks_pkg::KEY_W-1:0] next_key;

      assign occupied = IDX < count_ff;
      assign lt_in[i] = occupied && (cell_ff[i] < key_ff);
      assign eq_in[i] = occupied && (cell_ff[i] == key_ff);

      if (i == 0) begin : g_first
         assign prev_lt  = 1'b1;
         assign prev_key = key_ff;
      end else begin : g_inner
         assign prev_lt  = lt_ff[i-1];
         assign prev_key = cell_ff[i-1];
      end

      if (i == TABLE_DEPTH - 1) begin : g_last
         assign next_key = '0;
      end else begin : g_below
         assign next_key = cell_ff[i+1];
      end

      assign cell_in[i] = lt_ff[i] ? cell_ff[i] :
                          do_del   ? next_key   :
                          prev_lt  ? key_ff     : prev_key;
   end

   always_ff @(posedge clock) begin
      if (cmd.compare) begin
         lt_ff <= lt_in;
         eq_ff <= eq_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_ins || do_del) begin
         for (int i = 0; i < TABLE_DEPTH; i++) begin
            cell_ff[i] <= cell_in[i];
         end
      end
   end

   // Command decision from the registered flags.
   assign hit  = |eq_ff;
   assign full = count_ff == FULL_COUNT;

   always_comb begin
      do_ins    = 1'b0;
      do_del    = 1'b0;
      status_in = suks_pkg::ST_NOCHANGE;
      unique case (cmd_ff)
         suks_pkg::CMD_INSERT: begin
            if (!hit) begin
               if (full) begin
                  status_in = suks_pkg::ST_FULL;
               end else begin
                  do_ins    = cmd.execute;
                  status_in = suks_pkg::ST_CHANGED;
               end
            end
         end
         suks_pkg::CMD_DELETE: begin
            if (hit) begin
               do_del    = cmd.execute;
               status_in = suks_pkg::ST_CHANGED;
            end
         end
         default: begin
            // Search and the unused code leave the table alone.
         end
      endcase
   end

   // Count update.
   always_comb begin
      if (do_ins) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_del) begin
         count_in = count_ff - CNT_W'(1);
      end else begin
         count_in = count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // Response register.
   always_ff @(posedge clock) begin
      if (cmd.execute) begin
         status_ff    <= status_in;
         found_ff     <= hit;
         rsp_count_ff <= suks_pkg::COUNT_W'(count_in);
      end
   end

   assign rsp_status  = status_ff;
   assign rsp_found   = found_ff;
   assign rsp_count   = rsp_count_ff;
   assign entry_count = count_ff;

endmodule

[rtl/sorted_unique_key_set_unit.sv]
// Sorted unique key set unit: keeps up to TABLE_DEPTH signed 32-bit keys in
// ascending order with no duplicates.
//
// Request channel (req_valid/req_ready): req_cmd selects insert, delete or
// search (the unused code acts as search); req_key is the key.
// Response channel (rsp_valid/rsp_ready): one transfer per request with
// rsp_status (changed, no change, full), rsp_found (key present before the
// operation) and rsp_count (keys stored afterwards, low 7 bits).
//
// A compare cycle registers one flag pair per slot, then an execute cycle
// shifts the slot row by one place and loads the response register. A new
// request is taken in the execute cycle, so it overlaps the end of the last
// one; its compare then sees the table after the one-place shift.
// When the receiver stalls, the result waits in the response register; the
// next request is still taken and compared, and it holds in execute until
// the response register frees.
// Reset empties the table (count zero) and drops any pending response.
// Depends on suks_pkg, suks_ctrl and suks_datapath.
module sorted_unique_key_set_unit #(
   parameter int TABLE_DEPTH = suks_pkg::TABLE_DEPTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [suks_pkg::CMD_W-1:0]        req_cmd,
   input  logic signed [suks_pkg::KEY_W-1:0] req_key,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [suks_pkg::STATUS_W-1:0]     rsp_status,
   output logic                              rsp_found,
   output logic [suks_pkg::COUNT_W-1:0]      rsp_count
);

   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

   suks_pkg::ctrl_cmd_type ctrl_cmd;
   logic [CNT_W-1:0]       entry_count;

   // Sequencer.
   suks_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (ctrl_cmd)
   );

   // Slot row, count and response register.
   suks_datapath #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (ctrl_cmd),
      .req_cmd     (req_cmd),
      .req_key     (req_key),
      .rsp_status  (rsp_status),
      .rsp_found   (rsp_found),
      .rsp_count   (rsp_count),
      .entry_count (entry_count)
   );

`ifndef NO_ASSERTIONS
   // The number of stored keys never passes the table size.
   assert property (@(posedge clock) disable iff (reset)
      entry_count <= CNT_W'(TABLE_DEPTH))
      else $error("entry count exceeds table depth");

   // A refused insert never reports the key as present.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == suks_pkg::ST_FULL) |-> !rsp_found)
      else $error("full status with found flag set");

   // A request transfer is always followed by a compare cycle that takes nothing.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken during compare cycle");

   // A change reported with the key present can only come from a delete,
   // which leaves the table below full.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_found && (rsp_status == suks_pkg::ST_CHANGED)
         |-> entry_count < CNT_W'(TABLE_DEPTH) || !$stable(entry_count))
      else $error("delete left the table full");
`endif

endmodule
